[hw/rtl/avat_pkg.sv]
// shared types and constants of the vector angle core
package avat_pkg;

	// default coordinate width of the input vector
	localparam int COORD_BITS_DEF = 16;

	// 1.12 ratio: twelve fraction bits, thirteen quotient bits in all
	localparam int FRAC_BITS  = 12;
	localparam int RATIO_BITS = FRAC_BITS + 1;
	localparam int ANGLE_BITS = 12;

	// polynomial datapath widths
	localparam int SQ_BITS   = 2 * RATIO_BITS;
	localparam int LIN_BITS  = 22;
	localparam int CUB_BITS  = 20;
	localparam int OCT_BITS  = LIN_BITS - FRAC_BITS;

	localparam logic [9:0] POLY_LIN = 10'd651;
	localparam logic [7:0] POLY_CUB = 8'd139;

	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 12'd1024;
	localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 12'd2048;

	// octant folding decisions that travel with each beat
	typedef struct packed {
		logic zero;
		logic swapped;
		logic neg_x;
		logic neg_y;
	} flags_t;

endpackage

[hw/rtl/avat_div_cell.sv]
// one restoring division cell: one quotient bit per cell, registered
module avat_div_cell #(
	parameter int COORD_BITS = avat_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [COORD_BITS-2:0]                in_rem,
	input  logic [COORD_BITS-1:0]                in_den,
	input  logic [avat_pkg::RATIO_BITS-1:0]      in_q,
	input  logic                                 in_bit,
	input  avat_pkg::flags_t                     in_flags,
	output logic                                 out_valid,
	output logic [COORD_BITS-2:0]                out_rem,
	output logic [COORD_BITS-1:0]                out_den,
	output logic [avat_pkg::RATIO_BITS-1:0]      out_q,
	output avat_pkg::flags_t                     out_flags
);
	import avat_pkg::*;

	logic [COORD_BITS-1:0] trial;
	logic [COORD_BITS-1:0] diff;
	logic                  ge;
	logic [COORD_BITS-1:0] rem_next;

	// shift the next dividend bit into the remainder and try a subtract
	assign trial    = {in_rem, in_bit};
	assign ge       = (trial >= in_den);
	assign diff     = trial - in_den;
	assign rem_next = ge ? diff : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem   <= rem_next[COORD_BITS-2:0];
			out_den   <= in_den;
			out_q     <= {in_q[RATIO_BITS-2:0], ge};
			out_flags <= in_flags;
		end
	end

endmodule

[hw/rtl/avat_poly.sv]
// cubic octant fit and quadrant mirroring, four register stages
module avat_poly (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [avat_pkg::RATIO_BITS-1:0]      in_ratio,
	input  avat_pkg::flags_t                     in_flags,
	output logic                                 out_valid,
	output logic [avat_pkg::ANGLE_BITS-1:0]      out_angle
);
	import avat_pkg::*;

	logic [SQ_BITS-1:0]      sq_w;
	logic [SQ_BITS-1:0]      cube_w;
	logic [LIN_BITS:0]       lin_w;
	logic [CUB_BITS:0]       cub_w;
	logic [LIN_BITS-1:0]     diff_w;

	logic [RATIO_BITS-1:0]   ratio_s1;
	logic [RATIO_BITS-1:0]   sq_s1;
	logic [LIN_BITS-1:0]     lin_s1;
	flags_t                  flags_s1;
	logic                    valid_s1;

	logic [RATIO_BITS-1:0]   cube_s2;
	logic [LIN_BITS-1:0]     lin_s2;
	flags_t                  flags_s2;
	logic                    valid_s2;

	logic [CUB_BITS-1:0]     cub_s3;
	logic [LIN_BITS-1:0]     lin_s3;
	flags_t                  flags_s3;
	logic                    valid_s3;

	logic [OCT_BITS-1:0]     oct_s4;
	flags_t                  flags_s4;
	logic                    valid_s4;

	logic [ANGLE_BITS-1:0]   a_oct;
	logic [ANGLE_BITS-1:0]   a_swp;
	logic [ANGLE_BITS-1:0]   a_negx;
	logic [ANGLE_BITS-1:0]   a_negy;

	assign sq_w   = {{RATIO_BITS{1'b0}}, in_ratio} * {{RATIO_BITS{1'b0}}, in_ratio};
	assign lin_w  = {10'd0, in_ratio} * {13'd0, POLY_LIN};
	assign cube_w = {{RATIO_BITS{1'b0}}, sq_s1} * {{RATIO_BITS{1'b0}}, ratio_s1};
	assign cub_w  = {8'd0, cube_s2} * {13'd0, POLY_CUB};
	assign diff_w = lin_s3 - {{(LIN_BITS-CUB_BITS){1'b0}}, cub_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// r^2 >> 12 and the linear term
			ratio_s1 <= in_ratio;
			sq_s1    <= sq_w[2*FRAC_BITS:FRAC_BITS];
			lin_s1   <= lin_w[LIN_BITS-1:0];
			flags_s1 <= in_flags;
			// r^3 >> 12
			cube_s2  <= cube_w[2*FRAC_BITS:FRAC_BITS];
			lin_s2   <= lin_s1;
			flags_s2 <= flags_s1;
			// cubic term
			cub_s3   <= cub_w[CUB_BITS-1:0];
			lin_s3   <= lin_s2;
			flags_s3 <= flags_s2;
			// first octant angle, clamped at zero
			oct_s4   <= (cub_s3 > lin_s3[CUB_BITS-1:0] && lin_s3[LIN_BITS-1:CUB_BITS] == '0)
				? '0 : diff_w[LIN_BITS-1:FRAC_BITS];
			flags_s4 <= flags_s3;
		end
	end

	// mirror into the right octant, arithmetic wraps modulo a full turn
	assign a_oct  = {{(ANGLE_BITS-OCT_BITS){1'b0}}, oct_s4};
	assign a_swp  = flags_s4.swapped ? (QUARTER_TURN - a_oct) : a_oct;
	assign a_negx = flags_s4.neg_x ? (HALF_TURN - a_swp) : a_swp;
	assign a_negy = flags_s4.neg_y ? ({ANGLE_BITS{1'b0}} - a_negx) : a_negx;

	assign out_angle = flags_s4.zero ? '0 : a_negy;
	assign out_valid = valid_s4;

endmodule

[hw/rtl/vector_angle_atan2_core.sv]
// top level of the vector angle core: octant fold, divider cell chain, fit, output skid
//
// Gives the angle of a signed vector (y_coord, x_coord) in units of 4096 per
// full turn (1024 is 90 degrees); a zero vector gives 0. One beat is taken
// every cycle while the output side keeps up: a fold stage takes magnitudes
// and swaps so that y <= x, a chain of thirteen division cells forms the 1.12
// ratio y*4096/x one quotient bit per cell, four stages evaluate
// r*651 - r^3*139 (scaled by 2^-12) and the final mirror for swap and signs,
// and an output register with one skid entry holds results. in_stall is
// driven straight from the skid register, so it never depends combinationally
// on out_stall; the pipeline freezes only while the skid entry is full.
module vector_angle_atan2_core #(
	parameter int COORD_BITS = avat_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input beats
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        y_coord,
	input  logic signed [COORD_BITS-1:0]        x_coord,
	// result beats
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [avat_pkg::ANGLE_BITS-1:0]     angle
);
	import avat_pkg::*;

	localparam int NCELL = RATIO_BITS;

	// pipeline advance, frozen while the skid entry holds a beat
	logic en;

	// fold stage
	logic [COORD_BITS-1:0] xu, yu, ax, ay, num, den;
	logic                  swp;
	logic                  valid_s1;
	logic [COORD_BITS-2:0] rem_s1;
	logic                  lsb_s1;
	logic [COORD_BITS-1:0] den_s1;
	flags_t                flags_s1;

	// divider chain taps
	logic                   v_c   [0:NCELL];
	logic [COORD_BITS-2:0]  rem_c [0:NCELL];
	logic [COORD_BITS-1:0]  den_c [0:NCELL];
	logic [RATIO_BITS-1:0]  q_c   [0:NCELL];
	flags_t                 fl_c  [0:NCELL];

	// fit output
	logic                   poly_valid;
	logic [ANGLE_BITS-1:0]  poly_angle;

	// output register and skid entry
	logic                   out_valid_q;
	logic [ANGLE_BITS-1:0]  angle_q;
	logic                   skid_valid_q;
	logic [ANGLE_BITS-1:0]  skid_angle_q;
	logic                   push, pop;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// magnitudes: the most negative value maps to 2^(COORD_BITS-1) exactly
	assign xu  = x_coord;
	assign yu  = y_coord;
	assign ax  = xu[COORD_BITS-1] ? (~xu + 1'b1) : xu;
	assign ay  = yu[COORD_BITS-1] ? (~yu + 1'b1) : yu;
	assign swp = (ay > ax);
	assign num = swp ? ax : ay;
	assign den = swp ? ay : ax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// the first cell shifts the low numerator bit back in
			rem_s1           <= num[COORD_BITS-1:1];
			lsb_s1           <= num[0];
			den_s1           <= den;
			flags_s1.zero    <= (xu == '0) && (yu == '0);
			flags_s1.swapped <= swp;
			flags_s1.neg_x   <= xu[COORD_BITS-1];
			flags_s1.neg_y   <= yu[COORD_BITS-1];
		end
	end

	assign v_c[0]   = valid_s1;
	assign rem_c[0] = rem_s1;
	assign den_c[0] = den_s1;
	assign q_c[0]   = '0;
	assign fl_c[0]  = flags_s1;

	// one quotient bit per cell, the numerator's fraction bits shift in as zero
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		avat_div_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[i]),
			.in_rem    (rem_c[i]),
			.in_den    (den_c[i]),
			.in_q      (q_c[i]),
			.in_bit    ((i == 0) ? lsb_s1 : 1'b0),
			.in_flags  (fl_c[i]),
			.out_valid (v_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_den   (den_c[i+1]),
			.out_q     (q_c[i+1]),
			.out_flags (fl_c[i+1])
		);
	end

	avat_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_c[NCELL]),
		.in_ratio  (q_c[NCELL]),
		.in_flags  (fl_c[NCELL]),
		.out_valid (poly_valid),
		.out_angle (poly_angle)
	);

	// a beat leaves the fit stage only while the pipeline advances
	assign push = en && poly_valid;
	assign pop  = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				angle_q <= skid_angle_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				angle_q <= poly_angle;
			end else begin
				skid_angle_q <= poly_angle;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;

	// skid entry is only ever filled behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full with empty output register");

	// skid fills only when the output was stalled with a beat
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled without a stalled output beat");

	// a full skid entry is released only by a taken output beat
	a_skid_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_valid_q) |-> $past(!out_stall))
		else $error("skid entry dropped while output stalled");

	// the division remainder stays below the divisor at the end of the chain
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_c[NCELL] && !fl_c[NCELL].zero) |->
			({1'b0, rem_c[NCELL]} < den_c[NCELL]))
		else $error("division remainder not below divisor");

endmodule

[test/tb.sv]
// testbench for the vector angle core: directed and random vectors against a local predictor
module tb;

	import avat_pkg::*;

	localparam int CW          = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic signed [CW-1:0]   y_coord;
	logic signed [CW-1:0]   x_coord;
	logic                   out_valid;
	logic                   out_stall;
	logic [ANGLE_BITS-1:0]  angle;

	// angles still owed by the core, oldest first
	logic [ANGLE_BITS-1:0]  pending_angles[$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  in_gaps_on     = 1'b1;
	int  out_stall_pct  = 30;
	int  hold_req       = 0;

	vector_angle_atan2_core #(
		.COORD_BITS(CW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.y_coord  (y_coord),
		.x_coord  (x_coord),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.angle    (angle)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// angle of (y, x) in 4096-per-turn units: octant fold, cubic fit, mirror back
	function automatic logic [ANGLE_BITS-1:0] predict_angle(logic signed [CW-1:0] y,
			logic signed [CW-1:0] x);
		longint sy, sx, ay, ax, tmp, r, r3, lin, cub, oct, ang;
		bit     swap;
		sy = y;
		sx = x;
		if (sy == 0 && sx == 0)
			return '0;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		swap = (ay > ax);
		if (swap) begin
			tmp = ax;
			ax = ay;
			ay = tmp;
		end
		r   = (ay << FRAC_BITS) / ax;
		r3  = (((r * r) >> FRAC_BITS) * r) >> FRAC_BITS;
		lin = r * longint'(POLY_LIN);
		cub = r3 * longint'(POLY_CUB);
		oct = (cub > lin) ? 0 : ((lin - cub) >> FRAC_BITS);
		ang = oct;
		if (swap)
			ang = longint'(QUARTER_TURN) - ang;
		if (sx < 0)
			ang = longint'(HALF_TURN) - ang;
		if (sy < 0)
			ang = -ang;
		return ang[ANGLE_BITS-1:0];
	endfunction

	// mostly short, now and then long
	function automatic int idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// vector shapes that reach the interesting parts of the fit and the folding
	function automatic void rand_vector(output logic signed [CW-1:0] y,
			output logic signed [CW-1:0] x);
		int unsigned shape;
		int          d;
		shape = $urandom_range(0, 9);
		case (shape) inside
			[0:3]: begin
				y = CW'($urandom);
				x = CW'($urandom);
			end
			4: begin
				y = CW'($urandom_range(0, 16) - 8);
				x = CW'($urandom_range(0, 16) - 8);
			end
			5: begin
				// close to the diagonals, both sides of y == x
				x = CW'($urandom);
				d = $urandom_range(0, 4) - 2;
				y = CW'(x + d);
				if ($urandom_range(0, 1))
					y = -y;
			end
			6: begin
				// on or next to an axis
				y = CW'($urandom);
				x = CW'($urandom_range(0, 2) - 1);
				if ($urandom_range(0, 1)) begin
					x = y;
					y = CW'($urandom_range(0, 2) - 1);
				end
			end
			7: begin
				y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
				x = $urandom_range(0, 1) ? 16'sh8000 : CW'($urandom);
				if ($urandom_range(0, 1)) begin
					d = int'(y);
					y = x;
					x = CW'(d);
				end
			end
			default: begin
				// tiny against huge
				y = CW'($urandom_range(0, 64) - 32);
				x = CW'($urandom);
				if ($urandom_range(0, 1)) begin
					d = int'(y);
					y = x;
					x = CW'(d);
				end
			end
		endcase
	endfunction

	task automatic note_mismatch(string what, int exp_val, int act_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s expected %0d actual %0d",
				cycle_count, what, exp_val, act_val);
	endtask

	// offer one vector, wait for the core to take it, then maybe idle
	task automatic send_vec(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
		int gap;
		in_valid <= 1'b1;
		y_coord  <= y;
		x_coord  <= x;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pending_angles.push_back(predict_angle(y, x));
		gap = in_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		while (pending_angles.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_vec(0, 0);             // zero vector
		send_vec(0, 1);
		send_vec(1, 0);
		send_vec(0, -1);
		send_vec(-1, 0);
		send_vec(32767, 32767);     // on the diagonal, no swap
		send_vec(-32768, -32768);   // most negative on both sides
		send_vec(32767, -32768);
		send_vec(-32768, 32767);
		send_vec(0, -32768);
		send_vec(-32768, 0);        // wraps to three quarters
		send_vec(0, 32767);
		send_vec(32767, 0);
		send_vec(1, 32767);
		send_vec(32767, 1);
		send_vec(-1, -32768);       // lands on the half turn, wraps
		send_vec(-32768, -1);
		send_vec(1, 1);
		send_vec(-1, -1);
		send_vec(1, -1);
		send_vec(-1, 1);
		send_vec(100, 101);
		send_vec(101, 100);
		send_vec(-5, 3);
		in_valid <= 1'b0;
		drain_results();
	endtask

	task automatic test_random(int count, bit gaps, int stall_pct);
		logic signed [CW-1:0] y, x;
		in_gaps_on    = gaps;
		out_stall_pct = stall_pct;
		repeat (count) begin
			rand_vector(y, x);
			send_vec(y, x);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver holds off long enough for the pipe and skid to fill, sender keeps pushing
	task automatic test_backpressure();
		logic signed [CW-1:0] y, x;
		in_gaps_on = 1'b0;
		hold_req   = 300;
		repeat (80) begin
			rand_vector(y, x);
			send_vec(y, x);
		end
		in_valid <= 1'b0;
		// sender stays quiet until every angle is back
		drain_results();
		in_gaps_on = 1'b1;
	endtask

	// receiver side: random stall runs, or a long hold when one is asked for
	initial begin
		int run_left;
		bit stalled;
		out_stall <= 1'b0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_stall <= 1'b1;
				run_left = hold_req;
				hold_req = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				stalled = ($urandom_range(0, 99) < out_stall_pct);
				run_left = idle_len();
				out_stall <= stalled;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		logic [ANGLE_BITS-1:0] exp_angle;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				note_mismatch("unexpected angle, nothing pending", -1, int'(angle));
			end else begin
				exp_angle = pending_angles.pop_front();
				if (angle !== exp_angle)
					note_mismatch("angle", int'(exp_angle), int'(angle));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vector_angle_atan2_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		y_coord  <= '0;
		x_coord  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(900, 1'b1, 30);
		test_backpressure();
		test_random(250, 1'b0, 0);
		test_random(400, 1'b1, 70);
		test_random(200, 1'b1, 10);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_angles.size() != 0)
			note_mismatch("angles never delivered", 0, pending_angles.size());
		if (mismatch_count == 0)
			$display("vector_angle_atan2_core test passed");
		else
			$display("vector_angle_atan2_core test failed");
		$finish;
	end

endmodule
